// File: hdl/accalu_pkg.sv
// Shared types, operation codes and flag positions for the accumulator ALU.
// Also holds the restoring-divide step function used by every divide stage.
// No dependencies.
package accalu_pkg;

   localparam logic [2:0] MODE_DAA = 3'd0;
   localparam logic [2:0] MODE_CPL = 3'd1;
   localparam logic [2:0] MODE_NEG = 3'd2;
   localparam logic [2:0] MODE_CCF = 3'd3;
   localparam logic [2:0] MODE_SCF = 3'd4;
   localparam logic [2:0] MODE_RCF = 3'd5;
   localparam logic [2:0] MODE_MUL = 3'd6;
   localparam logic [2:0] MODE_DIV = 3'd7;

   // flag byte: S Z I H X V N C from bit 7 down
   localparam int FLAG_S = 7;
   localparam int FLAG_Z = 6;
   localparam int FLAG_H = 4;
   localparam int FLAG_X = 3;
   localparam int FLAG_V = 2;
   localparam int FLAG_N = 1;
   localparam int FLAG_C = 0;

   localparam int DIV_STEPS_PER_STAGE = 4;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  acc;
      logic [7:0]  flg;
      logic [15:0] pair;   // product for mul, original HL otherwise
      logic [7:0]  dvs;
      logic [7:0]  rem;
      logic [15:0] quo;    // dividend shifts out, quotient shifts in
   } stage_type;

   // Four restoring-divide steps on the partial remainder.
   function automatic stage_type div_steps(stage_type s);
      stage_type   r;
      logic [8:0]  t;
      logic        qbit;
      r = s;
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
         t = {r.rem, r.quo[15]};
         if (t >= {1'b0, r.dvs}) begin
            r.rem = 8'(t - {1'b0, r.dvs});
            qbit  = 1'b1;
         end else begin
            r.rem = t[7:0];
            qbit  = 1'b0;
         end
         r.quo = {r.quo[14:0], qbit};
      end
      return r;
   endfunction

endpackage

// File: hdl/accalu_flag_unit.sv
// Accumulator and flag result for the single-byte operations (daa, cpl, neg,
// ccf, scf, rcf). Mul and div pass A and F through. Uses accalu_pkg.
module accalu_flag_unit
   import accalu_pkg::*;
(
   input  logic [2:0] mode,
   input  logic [7:0] acc_in,
   input  logic [7:0] flags_in,
   output logic [7:0] acc_res,
   output logic [7:0] flags_res
);

   always_comb begin
      logic [7:0] a;
      logic [7:0] f;
      logic [8:0] sum;
      a = acc_in;
      f = flags_in;
      sum = '0;
      unique case (mode) inside
         MODE_DAA: begin
            if (a[3:0] > 4'd9 || f[FLAG_H]) begin
               f[FLAG_H] = (a[3:0] > 4'd9);
               sum = {1'b0, a} + 9'h006;
               f[FLAG_C] = sum[8];
               f[FLAG_X] = sum[8];
               a = sum[7:0];
            end
            if (a[7:4] > 4'd9 || f[FLAG_C]) begin
               sum = {1'b0, a} + 9'h060;
               f[FLAG_C] = sum[8];
               a = sum[7:0];
            end
         end
         MODE_CPL: begin
            a = ~a;
            f[FLAG_H] = 1'b1;
            f[FLAG_N] = 1'b1;
         end
         MODE_NEG: begin
            f[FLAG_N] = 1'b1;
            f[FLAG_V] = (a == 8'h80);
            f[FLAG_C] = (a != 8'h00);
            if (a != 8'h00) begin
               f[FLAG_X] = 1'b1;
            end
            f[FLAG_H] = (a[3:0] == 4'h0);
            a = 8'(8'h00 - a);
            f[FLAG_S] = a[7];
            f[FLAG_Z] = (a == 8'h00);
         end
         MODE_CCF: begin
            f[FLAG_C] = ~f[FLAG_C];
            f[FLAG_X] = ~f[FLAG_X];
            f[FLAG_N] = 1'b0;
         end
         MODE_SCF: begin
            f[FLAG_C] = 1'b1;
            f[FLAG_X] = 1'b1;
            f[FLAG_N] = 1'b0;
            f[FLAG_H] = 1'b0;
         end
         MODE_RCF: begin
            f[FLAG_C] = 1'b0;
            f[FLAG_X] = 1'b0;
            f[FLAG_N] = 1'b0;
            f[FLAG_H] = 1'b0;
         end
         MODE_MUL, MODE_DIV: begin
            a = acc_in;
         end
         default: begin
            a = acc_in;
         end
      endcase
      acc_res   = a;
      flags_res = f;
   end

endmodule

// File: hdl/accalu_top_dummy_guard.sv
// Output stage helper: finishes the divide (last four steps) and forms the
// final HL pair and flags for mul and div. Uses accalu_pkg.
module accalu_finish
   import accalu_pkg::*;
(
   input  stage_type   stg,
   output logic [7:0]  flags_res,
   output logic [15:0] pair_res
);

   always_comb begin
      stage_type d;
      d = div_steps(stg);
      flags_res = stg.flg;
      pair_res  = stg.pair;
      if (stg.mode == MODE_DIV) begin
         flags_res[FLAG_V] = 1'b0;
         if (stg.dvs == 8'h00) begin
            flags_res[FLAG_V] = 1'b1;
         end else if (d.quo[15:8] != 8'h00) begin
            flags_res[FLAG_V] = 1'b1;
            pair_res = {d.rem, stg.pair[7:0]};
         end else begin
            pair_res = {d.rem, d.quo[7:0]};
         end
      end
   end

endmodule

// File: hdl/accumulator_misc_alu_top.sv
// Accumulator/flag execution unit: daa, cpl, neg, ccf, scf, rcf, mul, div.
// Requests pass through s1, s2, s3 and the output register; throughput one
// request per cycle when not stalled. The 16/8 divide runs four restoring
// steps per stage over four stages, which sets the pipeline depth. All stages
// advance together when the output register is empty or being taken.
// Reset (synchronous, active high) clears the stage valid bits only.
module accumulator_misc_alu_top
   import accalu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_acc_in,
   input  logic [7:0]  req_flags_in,
   input  logic [15:0] req_pair_in,
   input  logic [7:0]  req_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_acc_out,
   output logic [7:0]  rsp_flags_out,
   output logic [15:0] rsp_pair_out
);

   logic        adv;
   logic [7:0]  acc_res;
   logic [7:0]  flg_res;
   logic [15:0] prod;
   stage_type   entry;
   stage_type   s1_ff, s1_in;
   stage_type   s2_ff, s2_in;
   stage_type   s3_ff, s3_in;
   logic        v1_ff, v2_ff, v3_ff, vo_ff;
   logic [7:0]  fin_flags;
   logic [15:0] fin_pair;
   logic [7:0]  acc_out_ff;
   logic [7:0]  flags_out_ff;
   logic [15:0] pair_out_ff;

   assign adv       = !vo_ff || rsp_ready;
   assign req_ready = adv;

   accalu_flag_unit u_flag (
      .mode      (req_mode),
      .acc_in    (req_acc_in),
      .flags_in  (req_flags_in),
      .acc_res   (acc_res),
      .flags_res (flg_res)
   );

   assign prod = req_pair_in[7:0] * req_operand;

   always_comb begin
      entry.mode = req_mode;
      entry.acc  = acc_res;
      entry.flg  = flg_res;
      entry.pair = (req_mode == MODE_MUL) ? prod : req_pair_in;
      entry.dvs  = req_operand;
      entry.rem  = 8'h00;
      entry.quo  = req_pair_in;
   end

   assign s1_in = div_steps(entry);
   assign s2_in = div_steps(s1_ff);
   assign s3_in = div_steps(s2_ff);

   accalu_finish u_finish (
      .stg       (s3_ff),
      .flags_res (fin_flags),
      .pair_res  (fin_pair)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         acc_out_ff   <= s3_ff.acc;
         flags_out_ff <= fin_flags;
         pair_out_ff  <= fin_pair;
      end
   end

   assign rsp_valid     = vo_ff;
   assign rsp_acc_out   = acc_out_ff;
   assign rsp_flags_out = flags_out_ff;
   assign rsp_pair_out  = pair_out_ff;

endmodule
